// ===== sv/kcl_pkg.sv =====
// Shared constants and types for the keypad code lock.
package kcl_pkg;

	localparam int unsigned KEY_W   = 5;
	localparam int unsigned TRIES_W = 4;
	localparam int unsigned DIGCNT_W = 3;

	localparam logic [KEY_W-1:0] KEY_CONFIRM = 5'd16;
	localparam logic [KEY_W-1:0] KEY_CLEAR   = 5'd17;
	localparam logic [KEY_W-1:0] KEY_SKIP_A  = 5'd18;
	localparam logic [KEY_W-1:0] KEY_SKIP_B  = 5'd19;
	localparam logic [KEY_W-1:0] KEY_NONE    = 5'd22;

	localparam logic [TRIES_W-1:0] TRIES_RESET = 4'd3;

	typedef struct packed {
		logic                locked;
		logic [TRIES_W-1:0]  tries_left;
		logic                code_accepted;
		logic                code_rejected;
		logic                beep_restart;
		logic                code_changed;
		logic [DIGCNT_W-1:0] digits_entered;
	} result_t;

endpackage

// ===== sv/keypad_code_lock_top.sv =====
// Keypad code lock: input register, key evaluation and result register.
//
// Key events enter on the in channel (func, key) with valid/ready and each
// produces exactly one result item on the out channel with valid/ready.
// An accepted item is held in the input register, evaluated against the lock
// state combinationally and written to the result register, which offers it
// on the out channel. Throughput is one item per cycle while the receiver
// takes each result as it is offered.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; the in channel then backs off until the result
// is taken. The cfg channel writes max_tries and is always ready; write it
// only with no item in flight.
// Reset clears both registers' valid bits, empties the entry buffer, loads
// the stored code 1,2,3,... , sets both entry positions to zero, tries to 3,
// max_tries to 3 and closes the lock.
module keypad_code_lock_top #(
	parameter int unsigned CODE_LENGTH = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic [kcl_pkg::KEY_W-1:0]    key,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         locked,
	output logic [kcl_pkg::TRIES_W-1:0]  tries_left,
	output logic                         code_accepted,
	output logic                         code_rejected,
	output logic                         beep_restart,
	output logic                         code_changed,
	output logic [kcl_pkg::DIGCNT_W-1:0] digits_entered,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [kcl_pkg::TRIES_W-1:0]  max_tries
);

	logic                        valid_s1;
	logic                        func_s1;
	logic [kcl_pkg::KEY_W-1:0]   key_s1;
	logic                        valid_s2;
	kcl_pkg::result_t            res_s2;
	kcl_pkg::result_t            res_comb;
	logic [kcl_pkg::TRIES_W-1:0] max_tries_q;
	logic                        advance;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tries_q <= kcl_pkg::TRIES_RESET;
		end else if (cfg_valid) begin
			max_tries_q <= max_tries;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			key_s1  <= key;
		end
	end

	kcl_core #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.func      (func_s1),
		.key       (key_s1),
		.max_tries (max_tries_q),
		.result    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid      = valid_s2;
	assign locked         = res_s2.locked;
	assign tries_left     = res_s2.tries_left;
	assign code_accepted  = res_s2.code_accepted;
	assign code_rejected  = res_s2.code_rejected;
	assign beep_restart   = res_s2.beep_restart;
	assign code_changed   = res_s2.code_changed;
	assign digits_entered = res_s2.digits_entered;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(code_accepted && code_rejected))
		else $error("accept and reject flagged together");

	a_beep_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (beep_restart == code_rejected))
		else $error("beep restart not tied to rejection");

	a_accept_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && code_accepted) |-> !locked)
		else $error("accepted code left lock closed");

	a_stays_open: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !locked) |=> (!out_valid || !locked))
		else $error("lock closed again after opening");

	a_accept_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(code_changed && (code_accepted || code_rejected)))
		else $error("code change flagged with an unlock confirm");

endmodule

// ===== sv/kcl_core.sv =====
// Lock state and the combinational key evaluation.
module kcl_core #(
	parameter int unsigned CODE_LENGTH = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          func,
	input  logic [kcl_pkg::KEY_W-1:0]     key,
	input  logic [kcl_pkg::TRIES_W-1:0]   max_tries,
	output kcl_pkg::result_t              result
);

	localparam int unsigned PW = $clog2(CODE_LENGTH + 1);
	localparam logic [PW-1:0] LEN = PW'(CODE_LENGTH);

	typedef logic [CODE_LENGTH-1:0][kcl_pkg::KEY_W-1:0] code_t;

	code_t                        entry_q, entry_n;
	code_t                        stored_q, stored_n;
	logic [PW-1:0]                unl_pos_q, unl_pos_n;
	logic [PW-1:0]                chg_pos_q, chg_pos_n;
	logic [kcl_pkg::TRIES_W-1:0]  tries_q, tries_n;
	logic                         lock_q, lock_n;

	code_t stored_rst;
	always_comb begin
		for (int i = 0; i < CODE_LENGTH; i++) begin
			stored_rst[i] = kcl_pkg::KEY_W'(i + 1);
		end
	end

	always_comb begin
		logic            is_digit;
		logic [PW-1:0]   pos_sel;
		logic            digit_wr;
		logic            accepted;
		logic            rejected;
		logic            changed;
		logic [PW+2:0]   pos_ext;

		is_digit = (key != kcl_pkg::KEY_CONFIRM) && (key != kcl_pkg::KEY_CLEAR) &&
			(key != kcl_pkg::KEY_SKIP_A) && (key != kcl_pkg::KEY_SKIP_B) &&
			(key != kcl_pkg::KEY_NONE);
		pos_sel  = func ? chg_pos_q : unl_pos_q;
		digit_wr = is_digit && (pos_sel < LEN);

		entry_n   = entry_q;
		stored_n  = stored_q;
		unl_pos_n = unl_pos_q;
		chg_pos_n = chg_pos_q;
		tries_n   = tries_q;
		lock_n    = lock_q;
		accepted  = 1'b0;
		rejected  = 1'b0;
		changed   = 1'b0;

		if (digit_wr) begin
			for (int i = 0; i < CODE_LENGTH; i++) begin
				if (pos_sel == PW'(i)) begin
					entry_n[i] = key;
				end
			end
			if (func) begin
				chg_pos_n = pos_sel + 1'b1;
			end else begin
				unl_pos_n = pos_sel + 1'b1;
			end
		end

		if (key == kcl_pkg::KEY_CONFIRM) begin
			if (!func) begin
				unl_pos_n = '0;
				if (entry_q == stored_q) begin
					accepted = 1'b1;
					tries_n  = max_tries;
					lock_n   = 1'b0;
				end else begin
					rejected = 1'b1;
					if (tries_q != '0) begin
						tries_n = tries_q - 1'b1;
					end
				end
			end else if (chg_pos_q == LEN) begin
				chg_pos_n = '0;
				stored_n  = entry_q;
				entry_n   = '0;
				changed   = 1'b1;
			end
		end

		if (key == kcl_pkg::KEY_CLEAR) begin
			entry_n = '0;
			if (func) begin
				chg_pos_n = '0;
			end else begin
				unl_pos_n = '0;
			end
		end

		pos_ext = {3'b000, (func ? chg_pos_n : unl_pos_n)};

		result.locked         = lock_n;
		result.tries_left     = tries_n;
		result.code_accepted  = accepted;
		result.code_rejected  = rejected;
		result.beep_restart   = rejected;
		result.code_changed   = changed;
		result.digits_entered = pos_ext[kcl_pkg::DIGCNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q   <= '0;
			stored_q  <= stored_rst;
			unl_pos_q <= '0;
			chg_pos_q <= '0;
			tries_q   <= kcl_pkg::TRIES_RESET;
			lock_q    <= 1'b1;
		end else if (fire) begin
			entry_q   <= entry_n;
			stored_q  <= stored_n;
			unl_pos_q <= unl_pos_n;
			chg_pos_q <= chg_pos_n;
			tries_q   <= tries_n;
			lock_q    <= lock_n;
		end
	end

endmodule
